@@ rtl/sqrt_rational_bounds_assert.svh @@
// ----------------------------------------------------------------------------
// sqrt_rational_bounds assertion macros
// shared concurrent assertion forms for the square root bounds block
// ----------------------------------------------------------------------------
`ifndef SQRT_RATIONAL_BOUNDS_ASSERT_SVH
`define SQRT_RATIONAL_BOUNDS_ASSERT_SVH

// same-cycle implication
`define SRB_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sqrtrb_pkg.sv @@
// ----------------------------------------------------------------------------
// sqrtrb_pkg
// types and constants shared by the square root bounds controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package sqrtrb_pkg;

  localparam int MUL_W = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = 3 * MUL_W;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_CAP = 2'd2;

  localparam logic [1:0] REG_ITER = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_TOL  = 2'd2;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_ZERO_UP,
    OP_SQ_MUL,
    OP_SQ_CMP,
    OP_R_MUL,
    OP_R_SET,
    OP_MUL_DEN_A,
    OP_ND_SET,
    OP_MUL_A_ND,
    OP_ACC_LOAD,
    OP_MUL_R_DEN,
    OP_NN_SET,
    OP_GCD_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_NUM2,
    OP_SQ_SAVE,
    OP_MUL_DEN2,
    OP_DD_SAVE,
    OP_MUL_DDLO_N,
    OP_MUL_DDHI_N,
    OP_BOUND_SET,
    OP_MUL_UPN_LOD,
    OP_X_SAVE,
    OP_MUL_LON_UPD,
    OP_DIFF,
    OP_MUL_LOD_UPD,
    OP_MUL_DDLO_TOL,
    OP_MUL_DDHI_TOL
  } op_t;

  typedef struct packed {
    logic n_zero;
    logic sq_last;
    logic a_big;
    logic nd_big;
    logic nn_big;
    logic gcd_done;
    logic have_lo;
    logic have_up;
    logic conv;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/sqrtrb_dp.sv @@
// ----------------------------------------------------------------------------
// sqrtrb_dp
// datapath: shared multiplier, wide accumulator, binary gcd and two-lane divider
// ----------------------------------------------------------------------------
`default_nettype none

module sqrtrb_dp import sqrtrb_pkg::*; #(
  parameter int RADICAND_BITS = 16,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic                     clk,
  input  wire op_t                      op,
  input  wire logic [RADICAND_BITS-1:0] in_n,
  input  wire logic [31:0]              tolerance,
  output logic [VALUE_BITS-1:0]         below_num,
  output logic [VALUE_BITS-1:0]         below_den,
  output logic [VALUE_BITS-1:0]         above_num,
  output logic [VALUE_BITS-1:0]         above_den,
  output dp_status_t                    st
);

  localparam int AW = (RADICAND_BITS + 1) / 2 + 1;
  localparam int VB = VALUE_BITS;
  localparam int GW = $clog2(VALUE_BITS);

  logic [RADICAND_BITS-1:0] n_r;
  logic [AW-1:0]            root_r, probe_r;
  logic [AW:0]              rr_r;
  logic [VB-1:0]            num_r, den_r, nd_r, nn_r;
  logic [VB-1:0]            gu_r, gv_r, g_r, rem1_r, rem2_r;
  logic [GW-1:0]            gk_r;
  logic [PROD_W-1:0]        p_r, sq_r, dd_r, x_r;
  logic [ACC_W-1:0]         acc_r;
  logic [VB-1:0]            lo_n_r, lo_d_r, up_n_r, up_d_r;
  logic                     have_lo_r, have_up_r;

  logic [MUL_W-1:0]  ma, mb;
  logic [AW-1:0]     cand;
  logic [PROD_W:0]   nd_sum, nn_sum;
  logic [ACC_W-1:0]  wide_sum;
  logic [VB:0]       sh1, sh2;

  assign cand     = root_r | probe_r;
  assign nd_sum   = (PROD_W+1)'(p_r) + (PROD_W+1)'(num_r);
  assign nn_sum   = (PROD_W+1)'(acc_r[PROD_W-1:0]) + (PROD_W+1)'(p_r);
  assign wide_sum = acc_r + (ACC_W'(p_r) << MUL_W);
  assign sh1      = {rem1_r, nn_r[VB-1]};
  assign sh2      = {rem2_r, nd_r[VB-1]};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (op)
      OP_SQ_MUL: begin
        ma = MUL_W'(cand);
        mb = MUL_W'(cand);
      end
      OP_R_MUL: begin
        ma = MUL_W'(root_r);
        mb = MUL_W'(root_r);
      end
      OP_MUL_DEN_A: begin
        ma = MUL_W'(den_r);
        mb = MUL_W'(root_r);
      end
      OP_MUL_A_ND: begin
        ma = MUL_W'(root_r);
        mb = MUL_W'(nd_r);
      end
      OP_MUL_R_DEN: begin
        ma = MUL_W'(rr_r);
        mb = MUL_W'(den_r);
      end
      OP_MUL_NUM2: begin
        ma = MUL_W'(num_r);
        mb = MUL_W'(num_r);
      end
      OP_MUL_DEN2: begin
        ma = MUL_W'(den_r);
        mb = MUL_W'(den_r);
      end
      OP_MUL_DDLO_N: begin
        ma = dd_r[MUL_W-1:0];
        mb = MUL_W'(n_r);
      end
      OP_MUL_DDHI_N: begin
        ma = dd_r[PROD_W-1:MUL_W];
        mb = MUL_W'(n_r);
      end
      OP_MUL_UPN_LOD: begin
        ma = MUL_W'(up_n_r);
        mb = MUL_W'(lo_d_r);
      end
      OP_MUL_LON_UPD: begin
        ma = MUL_W'(lo_n_r);
        mb = MUL_W'(up_d_r);
      end
      OP_MUL_LOD_UPD: begin
        ma = MUL_W'(lo_d_r);
        mb = MUL_W'(up_d_r);
      end
      OP_MUL_DDLO_TOL: begin
        ma = dd_r[MUL_W-1:0];
        mb = tolerance;
      end
      OP_MUL_DDHI_TOL: begin
        ma = dd_r[PROD_W-1:MUL_W];
        mb = tolerance;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(ma) * PROD_W'(mb);
    unique case (op)
      OP_LOAD: begin
        n_r       <= in_n;
        root_r    <= '0;
        probe_r   <= {1'b1, {(AW-1){1'b0}}};
        lo_n_r    <= '0;
        lo_d_r    <= '0;
        up_n_r    <= '0;
        up_d_r    <= '0;
        have_lo_r <= 1'b0;
        have_up_r <= 1'b0;
      end
      OP_ZERO_UP: up_d_r <= VB'(1);
      OP_SQ_CMP: begin
        if (p_r <= PROD_W'(n_r)) begin
          root_r <= cand;
        end
        probe_r <= probe_r >> 1;
      end
      OP_R_SET: begin
        rr_r  <= (AW+1)'(PROD_W'(n_r) - p_r);
        num_r <= VB'(root_r);
        den_r <= VB'(1);
      end
      OP_ND_SET:   nd_r  <= nd_sum[VB-1:0];
      OP_ACC_LOAD: acc_r <= ACC_W'(p_r);
      OP_NN_SET: begin
        nn_r <= nn_sum[VB-1:0];
        gu_r <= nn_sum[VB-1:0];
        gv_r <= nd_r;
        gk_r <= '0;
      end
      OP_GCD_STEP: begin
        if (!gu_r[0] && !gv_r[0]) begin
          gu_r <= gu_r >> 1;
          gv_r <= gv_r >> 1;
          gk_r <= gk_r + GW'(1);
        end else if (!gu_r[0]) begin
          gu_r <= gu_r >> 1;
        end else if (!gv_r[0]) begin
          gv_r <= gv_r >> 1;
        end else if (gu_r >= gv_r) begin
          gu_r <= (gu_r - gv_r) >> 1;
        end else begin
          gv_r <= (gv_r - gu_r) >> 1;
        end
      end
      OP_DIV_INIT: begin
        g_r    <= gv_r << gk_r;
        rem1_r <= '0;
        rem2_r <= '0;
      end
      OP_DIV_STEP: begin
        if (sh1 >= {1'b0, g_r}) begin
          rem1_r <= VB'(sh1 - {1'b0, g_r});
          nn_r   <= {nn_r[VB-2:0], 1'b1};
        end else begin
          rem1_r <= sh1[VB-1:0];
          nn_r   <= {nn_r[VB-2:0], 1'b0};
        end
        if (sh2 >= {1'b0, g_r}) begin
          rem2_r <= VB'(sh2 - {1'b0, g_r});
          nd_r   <= {nd_r[VB-2:0], 1'b1};
        end else begin
          rem2_r <= sh2[VB-1:0];
          nd_r   <= {nd_r[VB-2:0], 1'b0};
        end
      end
      OP_DIV_END: begin
        num_r <= nn_r;
        den_r <= nd_r;
      end
      OP_SQ_SAVE: sq_r <= p_r;
      OP_DD_SAVE: dd_r <= p_r;
      OP_BOUND_SET: begin
        if (ACC_W'(sq_r) < wide_sum) begin
          lo_n_r    <= num_r;
          lo_d_r    <= den_r;
          have_lo_r <= 1'b1;
        end else begin
          up_n_r    <= num_r;
          up_d_r    <= den_r;
          have_up_r <= 1'b1;
        end
      end
      OP_X_SAVE: x_r <= p_r;
      OP_DIFF:   x_r <= (x_r >= p_r) ? (x_r - p_r) : (p_r - x_r);
      default: begin
      end
    endcase
  end

  always_comb begin
    st.n_zero   = (n_r == '0);
    st.sq_last  = probe_r[0];
    st.a_big    = ((33'(root_r) >> VB) != '0);
    st.nd_big   = ((nd_sum >> VB) != '0);
    st.nn_big   = ((nn_sum >> VB) != '0);
    st.gcd_done = (gu_r == '0);
    st.have_lo  = have_lo_r;
    st.have_up  = have_up_r;
    st.conv     = (wide_sum >= {x_r, {MUL_W{1'b0}}});
  end

  assign below_num = lo_n_r;
  assign below_den = lo_d_r;
  assign above_num = up_n_r;
  assign above_den = up_d_r;

endmodule

`default_nettype wire

@@ rtl/sqrtrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// sqrtrb_ctrl
// controller: sequences root search, iterations, gcd, division and bound tests
// ----------------------------------------------------------------------------
`default_nettype none

`include "sqrt_rational_bounds_assert.svh"

module sqrtrb_ctrl import sqrtrb_pkg::*; #(
  parameter int VALUE_BITS     = 32,
  parameter int MAX_ITERATIONS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [5:0] iteration_count,
  input  wire logic       stop_mode,
  input  wire dp_status_t st,
  output op_t             op,
  output logic            busy,
  output logic            out_valid,
  output logic [1:0]      status
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam int LW = (IW > 6) ? IW : 6;
  localparam int CW = $clog2(VALUE_BITS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQRT = 8'b0000_0010,
    S_ITER = 8'b0000_0100,
    S_GCD  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_TOL  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [LW-1:0] limit, cfg_cnt, max_cnt, iter_ext;

  assign cfg_cnt  = LW'(iteration_count);
  assign max_cnt  = LW'(MAX_ITERATIONS);
  assign limit    = stop_mode ? max_cnt : ((cfg_cnt < max_cnt) ? cfg_cnt : max_cnt);
  assign iter_ext = LW'(iter_r);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    iter_nxt   = iter_r;
    status_nxt = status_r;
    op         = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op         = OP_LOAD;
          state_nxt  = S_SQRT;
          step_nxt   = 4'd0;
          iter_nxt   = '0;
          status_nxt = ST_OK;
        end
      end
      S_SQRT: begin
        unique case (step_r)
          4'd0: begin
            if (st.n_zero) begin
              op        = OP_ZERO_UP;
              state_nxt = S_DONE;
            end else begin
              op       = OP_SQ_MUL;
              step_nxt = 4'd1;
            end
          end
          4'd1: begin
            op       = OP_SQ_CMP;
            step_nxt = st.sq_last ? 4'd2 : 4'd0;
          end
          4'd2: begin
            op       = OP_R_MUL;
            step_nxt = 4'd3;
          end
          default: begin
            op = OP_R_SET;
            if (st.a_big) begin
              status_nxt = ST_OVF;
              state_nxt  = S_DONE;
            end else if (limit == '0) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ITER;
              step_nxt  = 4'd0;
            end
          end
        endcase
      end
      S_ITER: begin
        unique case (step_r)
          4'd0: begin
            op       = OP_MUL_DEN_A;
            step_nxt = 4'd1;
          end
          4'd1: begin
            if (st.nd_big) begin
              status_nxt = ST_OVF;
              state_nxt  = S_DONE;
            end else begin
              op       = OP_ND_SET;
              step_nxt = 4'd2;
            end
          end
          4'd2: begin
            op       = OP_MUL_A_ND;
            step_nxt = 4'd3;
          end
          4'd3: begin
            op       = OP_ACC_LOAD;
            step_nxt = 4'd4;
          end
          4'd4: begin
            op       = OP_MUL_R_DEN;
            step_nxt = 4'd5;
          end
          default: begin
            if (st.nn_big) begin
              status_nxt = ST_OVF;
              state_nxt  = S_DONE;
            end else begin
              op        = OP_NN_SET;
              state_nxt = S_GCD;
            end
          end
        endcase
      end
      S_GCD: begin
        if (st.gcd_done) begin
          op        = OP_DIV_INIT;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          op = OP_GCD_STEP;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (cnt_r == CW'(VALUE_BITS - 1)) begin
          state_nxt = S_CMP;
          step_nxt  = 4'd0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_CMP: begin
        step_nxt = step_r + 4'd1;
        unique case (step_r)
          4'd0: op = OP_DIV_END;
          4'd1: op = OP_MUL_NUM2;
          4'd2: op = OP_SQ_SAVE;
          4'd3: op = OP_MUL_DEN2;
          4'd4: op = OP_DD_SAVE;
          4'd5: op = OP_MUL_DDLO_N;
          4'd6: op = OP_ACC_LOAD;
          4'd7: op = OP_MUL_DDHI_N;
          default: begin
            op       = OP_BOUND_SET;
            iter_nxt = iter_r + IW'(1);
            step_nxt = 4'd0;
            if (stop_mode) begin
              state_nxt = S_TOL;
            end else if (iter_ext + LW'(1) >= limit) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ITER;
            end
          end
        endcase
      end
      S_TOL: begin
        step_nxt = step_r + 4'd1;
        unique case (step_r)
          4'd0: begin
            if (st.have_lo && st.have_up) begin
              op = OP_MUL_UPN_LOD;
            end else begin
              step_nxt = 4'd0;
              if (iter_ext >= limit) begin
                status_nxt = ST_CAP;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_ITER;
              end
            end
          end
          4'd1: op = OP_X_SAVE;
          4'd2: op = OP_MUL_LON_UPD;
          4'd3: op = OP_DIFF;
          4'd4: op = OP_MUL_LOD_UPD;
          4'd5: op = OP_DD_SAVE;
          4'd6: op = OP_MUL_DDLO_TOL;
          4'd7: op = OP_ACC_LOAD;
          4'd8: op = OP_MUL_DDHI_TOL;
          default: begin
            step_nxt = 4'd0;
            if (st.conv) begin
              state_nxt = S_DONE;
            end else if (iter_ext >= limit) begin
              status_nxt = ST_CAP;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_ITER;
            end
          end
        endcase
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= 4'd0;
      cnt_r    <= '0;
      iter_r   <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
      iter_r   <= iter_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign status    = status_r;

  `SRB_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "item not started")
  `SRB_ASSERT_NEXT(a_done_once, clk, rst_n, out_valid, !busy && !out_valid, "strobe repeated")
  `SRB_ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid, status <= ST_CAP, "bad status code")
  `SRB_ASSERT_IMPLY(a_fixed_no_cap, clk, rst_n, out_valid && !stop_mode, status != ST_CAP, "fixed cap")

endmodule

`default_nettype wire

@@ rtl/sqrt_rational_bounds.sv @@
// ----------------------------------------------------------------------------
// sqrt_rational_bounds
// rational lower and upper bounds on the square root of a radicand
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. the result fields are valid for exactly one
// cycle while out_valid is high; the receiver cannot stall, so nothing waits.
// one item is worked on at a time, set by the shared 32x32 multiplier, the
// bit-serial gcd and the one-bit-a-cycle divider.
// after the accepting edge comes the bit-by-bit root search, then per iteration
// the multiplies, the gcd steps and the two-lane divider; in tolerance mode each
// iteration adds a bound check, with the tolerance test once both bounds exist;
// then the result strobe. the next item is taken the cycle after the strobe.
// registers (apb, byte addresses 0, 4, 8): iteration count, stop mode,
// tolerance; to be written only while the block is idle, which it does not enforce.
// reset returns the controller to idle and the registers to 8, 0 and 4295.
// ----------------------------------------------------------------------------
`default_nettype none

module sqrt_rational_bounds import sqrtrb_pkg::*; #(
  parameter int RADICAND_BITS  = 16,
  parameter int VALUE_BITS     = 32,
  parameter int MAX_ITERATIONS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [RADICAND_BITS-1:0] in_n,
  output logic                          out_valid,
  output logic [VALUE_BITS-1:0]         out_below_num,
  output logic [VALUE_BITS-1:0]         out_below_den,
  output logic [VALUE_BITS-1:0]         out_above_num,
  output logic [VALUE_BITS-1:0]         out_above_den,
  output logic [1:0]                    out_status,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [3:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [5:0]  iteration_count_r;
  logic        stop_mode_r;
  logic [31:0] tolerance_r;
  logic        wr_en;
  logic [1:0]  reg_idx;
  op_t         op;
  dp_status_t  st;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iteration_count_r <= 6'd8;
      stop_mode_r       <= 1'b0;
      tolerance_r       <= 32'd4295;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ITER: iteration_count_r <= pwdata[5:0];
        REG_MODE: stop_mode_r       <= pwdata[0];
        REG_TOL:  tolerance_r       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ITER: prdata = {26'd0, iteration_count_r};
      REG_MODE: prdata = {31'd0, stop_mode_r};
      REG_TOL:  prdata = tolerance_r;
      default:  prdata = 32'd0;
    endcase
  end

  sqrtrb_ctrl #(
    .VALUE_BITS     (VALUE_BITS),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .iteration_count (iteration_count_r),
    .stop_mode       (stop_mode_r),
    .st              (st),
    .op              (op),
    .busy            (busy),
    .out_valid       (out_valid),
    .status          (out_status)
  );

  sqrtrb_dp #(
    .RADICAND_BITS (RADICAND_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .op        (op),
    .in_n      (in_n),
    .tolerance (tolerance_r),
    .below_num (out_below_num),
    .below_den (out_below_den),
    .above_num (out_above_num),
    .above_den (out_above_den),
    .st        (st)
  );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for sqrt_rational_bounds
// radicands go in over the start/busy handshake under a series of register
// settings written over apb while the block is idle. each result is checked
// field by field against a bit-exact predictor of the bounds and status.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
  logic [31:0] below_num;
  logic [31:0] below_den;
  logic [31:0] above_num;
  logic [31:0] above_den;
  logic [1:0]  status;
} bounds_t;

class bounds_scoreboard;
  logic [5:0]  iter_count = 6'd8;
  logic        stop_mode  = 1'b0;
  logic [31:0] tolerance  = 32'd4295;
  bounds_t     pending[$];
  int          mismatches = 0;

  function bounds_t compute_bounds(logic [15:0] n);
    bounds_t     res;
    logic [63:0] a, r, num, den, nd, nn, x, y, t, sq, dd, cand;
    logic [63:0] lon, lod, upn, upd, cu, cl, diff;
    logic [127:0] lhs, rhs;
    int          lim;
    bit          have_lo, have_up, conv;
    logic [1:0]  st;
    lon = 0; lod = 0; upn = 0; upd = 0; st = sqrtrb_pkg::ST_OK;
    have_lo = 0; have_up = 0; conv = 0;
    if (n == 0) begin
      res.below_num = 0; res.below_den = 0; res.above_num = 0; res.above_den = 1;
      res.status = sqrtrb_pkg::ST_OK;
      return res;
    end
    a = 0;
    for (int b = 8; b >= 0; b--) begin
      cand = a | (64'd1 << b);
      if (cand * cand <= 64'(n)) a = cand;
    end
    r = 64'(n) - a * a;
    num = a;
    den = 1;
    lim = stop_mode ? 64 : int'(iter_count);
    for (int i = 0; i < lim; i++) begin
      nd = den * a + num;
      if (nd > 64'hFFFF_FFFF) begin
        st = sqrtrb_pkg::ST_OVF;
        break;
      end
      nn = a * nd + r * den;
      if (nn > 64'hFFFF_FFFF) begin
        st = sqrtrb_pkg::ST_OVF;
        break;
      end
      x = nn; y = nd;
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      if (x == 0) x = 1;
      num = nn / x;
      den = nd / x;
      sq = num * num;
      dd = den * den;
      if (128'(sq) < 128'(dd) * 128'(n)) begin
        lon = num; lod = den; have_lo = 1;
      end else begin
        upn = num; upd = den; have_up = 1;
      end
      if (stop_mode && have_lo && have_up) begin
        cu = upn * lod;
        cl = lon * upd;
        diff = (cu >= cl) ? cu - cl : cl - cu;
        lhs = 128'(diff) << 32;
        rhs = 128'(lod * upd) * 128'(tolerance);
        if (!(rhs < lhs)) begin
          conv = 1;
          break;
        end
      end
    end
    if (stop_mode && !conv && st == sqrtrb_pkg::ST_OK) st = sqrtrb_pkg::ST_CAP;
    res.below_num = lon[31:0]; res.below_den = lod[31:0];
    res.above_num = upn[31:0]; res.above_den = upd[31:0];
    res.status = st;
    return res;
  endfunction

  function void note_radicand(logic [15:0] n);
    pending.push_back(compute_bounds(n));
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task check_result(bounds_t got);
    bounds_t want;
    if (pending.size() == 0) begin
      report_mismatch("result with no item outstanding", 32'd0, 32'd0);
      return;
    end
    want = pending.pop_front();
    if (got.below_num !== want.below_num)
      report_mismatch("below_num", got.below_num, want.below_num);
    if (got.below_den !== want.below_den)
      report_mismatch("below_den", got.below_den, want.below_den);
    if (got.above_num !== want.above_num)
      report_mismatch("above_num", got.above_num, want.above_num);
    if (got.above_den !== want.above_den)
      report_mismatch("above_den", got.above_den, want.above_den);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
  endtask
endclass

module testbench;
  import sqrtrb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_n = '0;
  logic        out_valid;
  logic [31:0] out_below_num, out_below_den, out_above_num, out_above_den;
  logic [1:0]  out_status;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          cycles = 0;

  bounds_scoreboard sb = new();

  sqrt_rational_bounds i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_n(in_n),
    .out_valid(out_valid), .out_below_num(out_below_num),
    .out_below_den(out_below_den), .out_above_num(out_above_num),
    .out_above_den(out_above_den), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 30000000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    bounds_t got;
    if (rst_n && out_valid) begin
      got.below_num = out_below_num; got.below_den = out_below_den;
      got.above_num = out_above_num; got.above_den = out_above_den;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  task write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ITER: sb.iter_count = val[5:0];
      REG_MODE: sb.stop_mode = val[0];
      default:  sb.tolerance = val;
    endcase
    @(posedge clk);
  endtask

  task configure(logic [5:0] iters, logic mode, logic [31:0] tol);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_ITER, 32'(iters));
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_TOL, tol);
    @(posedge clk);
  endtask

  task send_radicand(logic [15:0] v, bit drop);
    start <= 1'b1;
    in_n <= v;
    do @(posedge clk); while (busy);
    sb.note_radicand(v);
    if (drop) start <= 1'b0;
  endtask

  function logic [15:0] pick_radicand();
    logic [15:0] k;
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 300));
      1: begin
        k = 16'($urandom_range(0, 255));
        return k * k;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task run_items(int count, bit idle);
    bit gap, last;
    for (int i = 0; i < count; i++) begin
      gap = idle && ($urandom_range(0, 3) == 0);
      last = (i == count - 1);
      send_radicand(pick_radicand(), gap || last);
      if (gap && !last) repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  logic [15:0] directed[] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd16,
                              16'd99, 16'd1000, 16'd65535, 16'd65534, 16'd65025,
                              16'd65026, 16'd32768, 16'd255, 16'd256, 16'd257};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset register values first
    foreach (directed[i]) send_radicand(directed[i], i == directed.size() - 1);
    configure(6'd1, 1'b0, 32'd1);
    foreach (directed[i]) send_radicand(directed[i], i == directed.size() - 1);
    configure(6'd0, 1'b0, 32'd0);
    run_items(10, 1);
    configure(6'd63, 1'b0, 32'hFFFF_FFFF);
    run_items(20, 1);
    configure(6'd8, 1'b1, 32'd1);
    run_items(30, 1);
    configure(6'd8, 1'b1, 32'hFFFF_FFFF);
    run_items(40, 1);
    configure(6'd8, 1'b1, 32'd0);
    run_items(20, 1);
    configure(6'd8, 1'b1, 32'd4295);
    run_items(30, 1);
    for (int p = 0; p < 9; p++) begin
      configure(6'($urandom_range(0, 12)), 1'($urandom_range(0, 1)), $urandom);
      run_items(45, 1);
    end
    configure(6'($urandom_range(1, 10)), 1'b0, 32'd4295);
    run_items(40, 0);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire
